[hw/rtl/noc_vc_allocator_and_link_scheduler_unit_assert.svh]
// Assertion macros shared by the VC allocator and link scheduler RTL.
`ifndef NOC_VC_ALLOCATOR_AND_LINK_SCHEDULER_UNIT_ASSERT_SVH
`define NOC_VC_ALLOCATOR_AND_LINK_SCHEDULER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is asserted.
`define NOCVAS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("nocvas assertion failed");
// Clocked check that also holds during reset.
`define NOCVAS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("nocvas assertion failed");
`else
`define NOCVAS_ASSERT(name, clk, rst_n, prop)
`define NOCVAS_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

[hw/rtl/nocvas_pkg.sv]
// Types, constants and helpers of the VC allocator and link scheduler.
`timescale 1ns / 1ps
`default_nettype none
package nocvas_pkg;

  localparam int unsigned NUM_VNETS    = 4;
  localparam int unsigned VCS_IN_VNET  = 4;
  localparam int unsigned NUM_VCS      = 16;

  localparam int unsigned VNET_W     = 2;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned VC_W       = 4;
  localparam int unsigned CREDIT_W   = 4;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned BUSY_W     = 17;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned MASK_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [STAMP_W-1:0]  STAMP_INF  = {STAMP_W{1'b1}};
  localparam logic [BUSY_W-1:0]   BUSY_MAX   = {BUSY_W{1'b1}};
  localparam logic [CREDIT_W-1:0] CREDIT_MAX = {CREDIT_W{1'b1}};

  localparam logic [THR_W-1:0]     THR_RESET = 16'd50000;
  localparam logic [NUM_VNETS-1:0] ORD_RESET = '0;
  localparam logic [CREDIT_W-1:0]  BPV_RESET = 4'd4;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_CREDIT = 2'd1,
    FUNC_SCHED  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADLOCK_THR   = 2'd0,
    CFG_ORDERED_MASK   = 2'd1,
    CFG_BUFFERS_PER_VC = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EVAL   = 2'd1,
    ST_COMMIT = 2'd2
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [VNET_W-1:0]  vnet;
    logic [VC_W-1:0]    credit_vc;
    logic               credit_free;
    logic [MASK_W-1:0]  ready_mask;
    logic [MASK_W-1:0]  tail_mask;
  } in_t;

  typedef struct packed {
    logic            alloc_ok;
    logic [VC_W-1:0] alloc_vc;
    logic            deadlock;
    logic            send_ok;
    logic [VC_W-1:0] send_vc;
  } out_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } status_t;

  // Index of the lowest set bit, zero when none is set.
  function automatic logic [VC_W-1:0] lowest_set(input logic [NUM_VCS-1:0] vec);
    logic [VC_W-1:0] idx;
    idx = '0;
    for (int i = NUM_VCS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = VC_W'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/nocvas_ctrl.sv]
// Sequencing controller: accept, evaluate and commit one item at a time.
`timescale 1ns / 1ps
`default_nettype none
module nocvas_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire nocvas_pkg::status_t status_i,
  output nocvas_pkg::cmd_t         cmd_o
);

  nocvas_pkg::state_e state_q, state_d;
  logic               accept_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nocvas_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      nocvas_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = nocvas_pkg::ST_EVAL;
        end
      end
      nocvas_pkg::ST_EVAL: begin
        state_d = nocvas_pkg::ST_COMMIT;
      end
      nocvas_pkg::ST_COMMIT: begin
        // hold until the result slot frees; take the next transfer on the way out
        if (status_i.slot_free) begin
          state_d = in_valid_i ? nocvas_pkg::ST_EVAL : nocvas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nocvas_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    accept_ok     = 1'b0;
    cmd_o         = '0;
    case (state_q)
      nocvas_pkg::ST_IDLE: begin
        accept_ok = 1'b1;
      end
      nocvas_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
      end
      nocvas_pkg::ST_COMMIT: begin
        accept_ok    = status_i.slot_free;
        cmd_o.commit = status_i.slot_free;
      end
      default: begin
        accept_ok = 1'b0;
      end
    endcase
    cmd_o.load = in_valid_i & accept_ok;
    in_stall_o = ~accept_ok;
  end

endmodule
`default_nettype wire

[hw/rtl/nocvas_dp.sv]
// Datapath: VC state, allocation, credit handling, link arbitration, result slot.
`timescale 1ns / 1ps
`default_nettype none
module nocvas_dp (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire nocvas_pkg::cmd_t                      cmd_i,
  output nocvas_pkg::status_t                        status_o,
  input  wire nocvas_pkg::in_t                       in_data_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output nocvas_pkg::out_t                           out_data_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [nocvas_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [nocvas_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned NV  = nocvas_pkg::NUM_VNETS;
  localparam int unsigned VPV = nocvas_pkg::VCS_IN_VNET;
  localparam int unsigned NVC = nocvas_pkg::NUM_VCS;

  nocvas_pkg::in_t                        item_q;
  logic [nocvas_pkg::THR_W-1:0]           thr_q;
  logic [NV-1:0]                          omask_q;
  logic [nocvas_pkg::CREDIT_W-1:0]        credit_q [NVC];
  logic [NVC-1:0]                         active_q;
  logic [nocvas_pkg::STAMP_W-1:0]         stamp_q [NVC];
  logic [nocvas_pkg::PTR_W-1:0]           aptr_q [NV];
  logic [nocvas_pkg::BUSY_W-1:0]          busy_q [NV];
  logic [nocvas_pkg::VC_W-1:0]            lptr_q;
  logic [nocvas_pkg::STAMP_W-1:0]         seq_q;
  logic [NVC-1:0]                         elig_q, elig_d;
  logic [NVC-1:0]                         blocked;
  nocvas_pkg::out_t                       out_q, res;
  logic                                   out_valid_q;

  // allocation
  logic [nocvas_pkg::PTR_W-1:0]           a_ptr, a_idx, a_next;
  logic [nocvas_pkg::PTR_W:0]             a_sum;
  logic [nocvas_pkg::VC_W-1:0]            a_base, a_vc, a_cand_vc;
  logic                                   a_found;
  logic [nocvas_pkg::BUSY_W-1:0]          busy_cur, busy_inc;
  logic                                   dl_hit;

  // link arbitration
  logic [NVC-1:0]                         above, upper;
  logic                                   s_any;
  logic [nocvas_pkg::VC_W-1:0]            s_vc;

  // ordered-vnet check: a ready sibling with an older stamp blocks the VC
  always_comb begin
    blocked = '0;
    for (int i = 0; i < NVC; i++) begin
      for (int k = 0; k < VPV; k++) begin
        if (item_q.ready_mask[(i / VPV) * VPV + k] &&
            (stamp_q[(i / VPV) * VPV + k] < stamp_q[i])) begin
          blocked[i] = 1'b1;
        end
      end
    end
    for (int i = 0; i < NVC; i++) begin
      elig_d[i] = item_q.ready_mask[i] && (credit_q[i] != '0) &&
                  !(omask_q[i / VPV] && blocked[i]);
    end
  end

  // first idle VC of the vnet, walking round-robin from its pointer
  always_comb begin
    a_ptr     = aptr_q[item_q.vnet];
    a_base    = nocvas_pkg::VC_W'(item_q.vnet * VPV);
    a_found   = 1'b0;
    a_idx     = a_ptr;
    a_vc      = '0;
    a_sum     = '0;
    a_cand_vc = '0;
    for (int d = 0; d < VPV; d++) begin
      a_sum = {1'b0, a_ptr} + (nocvas_pkg::PTR_W + 1)'(d);
      if (a_sum >= (nocvas_pkg::PTR_W + 1)'(VPV)) begin
        a_sum = a_sum - (nocvas_pkg::PTR_W + 1)'(VPV);
      end
      a_cand_vc = a_base + nocvas_pkg::VC_W'(a_sum);
      if (!a_found && !active_q[a_cand_vc]) begin
        a_found = 1'b1;
        a_idx   = a_sum[nocvas_pkg::PTR_W-1:0];
        a_vc    = a_cand_vc;
      end
    end
    a_sum = {1'b0, a_idx} + (nocvas_pkg::PTR_W + 1)'(1);
    if (a_sum >= (nocvas_pkg::PTR_W + 1)'(VPV)) begin
      a_sum = '0;
    end
    a_next   = a_found ? a_sum[nocvas_pkg::PTR_W-1:0] : a_ptr;
    busy_cur = busy_q[item_q.vnet];
    busy_inc = (busy_cur == nocvas_pkg::BUSY_MAX) ? busy_cur
                                                  : busy_cur + nocvas_pkg::BUSY_W'(1);
    dl_hit   = busy_inc > nocvas_pkg::BUSY_W'(thr_q);
  end

  // round-robin pick after the last granted VC
  always_comb begin
    for (int i = 0; i < NVC; i++) begin
      above[i] = nocvas_pkg::VC_W'(i) > lptr_q;
    end
    upper = elig_q & above;
    s_any = |elig_q;
    s_vc  = (|upper) ? nocvas_pkg::lowest_set(upper) : nocvas_pkg::lowest_set(elig_q);
  end

  always_comb begin
    res = '0;
    case (item_q.func)
      nocvas_pkg::FUNC_ALLOC: begin
        res.alloc_ok = a_found;
        res.alloc_vc = a_found ? a_vc : '0;
        res.deadlock = !a_found && dl_hit;
      end
      nocvas_pkg::FUNC_SCHED: begin
        res.send_ok = s_any;
        res.send_vc = s_any ? s_vc : '0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.eval) begin
      elig_q <= elig_d;
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= nocvas_pkg::THR_RESET;
      omask_q  <= nocvas_pkg::ORD_RESET;
      active_q <= '0;
      lptr_q   <= '0;
      seq_q    <= '0;
      for (int i = 0; i < NVC; i++) begin
        credit_q[i] <= nocvas_pkg::BPV_RESET;
        stamp_q[i]  <= nocvas_pkg::STAMP_INF;
      end
      for (int v = 0; v < NV; v++) begin
        aptr_q[v] <= '0;
        busy_q[v] <= '0;
      end
    end else if (cfg_we_i) begin
      case (nocvas_pkg::cfg_idx_e'(cfg_idx_i))
        nocvas_pkg::CFG_DEADLOCK_THR: begin
          thr_q <= cfg_wdata_i[nocvas_pkg::THR_W-1:0];
        end
        nocvas_pkg::CFG_ORDERED_MASK: begin
          omask_q <= cfg_wdata_i[NV-1:0];
        end
        nocvas_pkg::CFG_BUFFERS_PER_VC: begin
          // reload every credit count with the new depth
          for (int i = 0; i < NVC; i++) begin
            credit_q[i] <= cfg_wdata_i[nocvas_pkg::CREDIT_W-1:0];
          end
        end
        default: begin
          thr_q <= thr_q;
        end
      endcase
    end else if (cmd_i.commit) begin
      case (item_q.func)
        nocvas_pkg::FUNC_ALLOC: begin
          aptr_q[item_q.vnet] <= a_next;
          if (a_found) begin
            busy_q[item_q.vnet] <= '0;
            active_q[a_vc]      <= 1'b1;
            stamp_q[a_vc]       <= seq_q;
            seq_q               <= seq_q + nocvas_pkg::STAMP_W'(1);
          end else begin
            busy_q[item_q.vnet] <= busy_inc;
          end
        end
        nocvas_pkg::FUNC_CREDIT: begin
          for (int i = 0; i < NVC; i++) begin
            if (nocvas_pkg::VC_W'(i) == item_q.credit_vc) begin
              if (credit_q[i] != nocvas_pkg::CREDIT_MAX) begin
                credit_q[i] <= credit_q[i] + nocvas_pkg::CREDIT_W'(1);
              end
            end
          end
          if (item_q.credit_free) begin
            active_q[item_q.credit_vc] <= 1'b0;
          end
        end
        nocvas_pkg::FUNC_SCHED: begin
          if (s_any) begin
            lptr_q <= s_vc;
            for (int i = 0; i < NVC; i++) begin
              if (nocvas_pkg::VC_W'(i) == s_vc) begin
                credit_q[i] <= credit_q[i] - nocvas_pkg::CREDIT_W'(1);
              end
            end
            if (item_q.tail_mask[s_vc]) begin
              stamp_q[s_vc] <= nocvas_pkg::STAMP_INF;
            end
          end
        end
        default: begin
          lptr_q <= lptr_q;
        end
      endcase
    end
  end

  // result slot: fill on commit, drain on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.slot_free = !out_valid_q || !out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

endmodule
`default_nettype wire

[hw/rtl/noc_vc_allocator_and_link_scheduler_unit.sv]
// Flow: an accepted item is registered, evaluated, then committed to the result slot;
// the controller's evaluate and commit steps pace the items, it takes the next item
// as the commit step completes, and a stalled result slot holds the commit step.
// Reset: asynchronous, active low; all VCs idle with full credit, stamps at
// infinity, pointers, busy counters and sequence at zero, config registers at reset values.
`timescale 1ns / 1ps
`default_nettype none
`include "noc_vc_allocator_and_link_scheduler_unit_assert.svh"
module noc_vc_allocator_and_link_scheduler_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire nocvas_pkg::in_t                   in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output nocvas_pkg::out_t                       out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [nocvas_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [nocvas_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  nocvas_pkg::cmd_t    cmd;
  nocvas_pkg::status_t status;

  nocvas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nocvas_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  `NOCVAS_ASSERT(a_no_commit_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> !cmd.commit)
  `NOCVAS_ASSERT(a_commit_needs_slot, clk_i, rst_ni, cmd.commit |-> status.slot_free)
  `NOCVAS_ASSERT(a_one_kind_of_result, clk_i, rst_ni, out_valid_o |-> !(out_data_o.alloc_ok && out_data_o.send_ok))
  `NOCVAS_ASSERT_ALWAYS(a_no_deadlock_on_success, clk_i, out_valid_o |-> !(out_data_o.alloc_ok && out_data_o.deadlock))

endmodule
`default_nettype wire
